/* src/sfc_pkg.sv */
// Shared types, constants and helper functions for the sensor frame checker.
package sfc_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TEMP_HIGH = 3'd0,
        REG_TEMP_LOW  = 3'd1,
        REG_HUM_HIGH  = 3'd2,
        REG_HUM_LOW   = 3'd3,
        REG_FAN_BAND  = 3'd4
    } cfg_reg_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_CRC_ERR = 2'd1,
        STATUS_RANGE   = 2'd2
    } status_t;

    // Byte position inside a frame
    typedef enum logic [2:0] {
        POS_T_MSB = 3'd0,
        POS_T_LSB = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_MSB = 3'd3,
        POS_H_LSB = 3'd4,
        POS_H_CRC = 3'd5
    } byte_pos_t;

    // Frame assembler to evaluation pipeline
    typedef struct packed {
        logic        done;
        logic        crc_ok;
        logic [15:0] raw_temp;
        logic [15:0] raw_hum;
    } sfc_frame_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 15;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Conversion scale factors and offset
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [16:0] DIV_CONST   = 17'd65535;

    // Accepted range of a good frame
    localparam logic signed [14:0] TEMP_MIN_OK = -15'sd4000;
    localparam logic signed [14:0] TEMP_MAX_OK = 15'sd12500;
    localparam logic [13:0]        HUM_MAX_OK  = 14'd10000;

    // Reset values of the limit registers
    localparam logic signed [14:0] TEMP_HIGH_RST = 15'sd4000;
    localparam logic signed [14:0] TEMP_LOW_RST  = 15'sd2000;
    localparam logic [13:0]        HUM_HIGH_RST  = 14'd6000;
    localparam logic [13:0]        HUM_LOW_RST   = 14'd3000;
    localparam logic [10:0]        FAN_BAND_RST  = 11'd200;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // floor(x / 65535) for x < 2^31: x>>16 is at most one short of the quotient
    function automatic logic [14:0] div_65535(input logic [30:0] x);
        logic [14:0] q0;
        logic [16:0] r0;
        q0 = x[30:16];
        r0 = {1'b0, x[15:0]} + {2'b00, q0};
        return q0 + {14'd0, (r0 >= DIV_CONST)};
    endfunction

endpackage

/* src/sfc_if.sv */
// Valid/ready channel interfaces for frame bytes and results.
interface sfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sfc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [14:0] temp_centi;
    logic [13:0]        hum_centi;
    logic               hum_alarm;
    logic               temp_alarm;
    logic               fan_on;

    modport source (output valid, output status, output temp_centi, output hum_centi,
                    output hum_alarm, output temp_alarm, output fan_on, input ready);
    modport sink   (input valid, input status, input temp_centi, input hum_centi,
                    input hum_alarm, input temp_alarm, input fan_on, output ready);
endinterface

/* src/sfc_frame_rx.sv */
// Byte counter, running CRC and raw word capture for one sensor frame.
module sfc_frame_rx
    import sfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] rx_byte,
    input  logic       frame_start,
    output sfc_frame_t frame
);

    byte_pos_t   count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] raw_temp_reg, raw_temp_next;
    logic [15:0] raw_hum_reg, raw_hum_next;
    logic        temp_good_reg, temp_good_next;

    byte_pos_t   pos;
    logic [7:0]  crc_base;
    logic [7:0]  crc_upd;
    logic        crc_match;

    // Start mark restarts count and CRC for this byte
    assign pos       = frame_start ? POS_T_MSB : count_reg;
    assign crc_base  = frame_start ? CRC_INIT : crc_reg;
    assign crc_upd   = crc8_byte(crc_base, rx_byte);
    assign crc_match = (rx_byte == crc_base);

    // Per-byte state update
    always_comb
    begin
        count_next     = count_reg;
        crc_next       = crc_reg;
        raw_temp_next  = raw_temp_reg;
        raw_hum_next   = raw_hum_reg;
        temp_good_next = temp_good_reg;
        frame          = '0;
        frame.raw_temp = raw_temp_reg;
        frame.raw_hum  = raw_hum_reg;
        if (take)
        begin
            unique case (pos)
                POS_T_MSB:
                begin
                    raw_temp_next = {rx_byte, raw_temp_reg[7:0]};
                    crc_next      = crc_upd;
                    count_next    = POS_T_LSB;
                end
                POS_T_LSB:
                begin
                    raw_temp_next = {raw_temp_reg[15:8], rx_byte};
                    crc_next      = crc_upd;
                    count_next    = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    temp_good_next = crc_match;
                    crc_next       = CRC_INIT;
                    count_next     = POS_H_MSB;
                end
                POS_H_MSB:
                begin
                    raw_hum_next = {rx_byte, raw_hum_reg[7:0]};
                    crc_next     = crc_upd;
                    count_next   = POS_H_LSB;
                end
                POS_H_LSB:
                begin
                    raw_hum_next = {raw_hum_reg[15:8], rx_byte};
                    crc_next     = crc_upd;
                    count_next   = POS_H_CRC;
                end
                POS_H_CRC:
                begin
                    frame.done   = 1'b1;
                    frame.crc_ok = temp_good_reg & crc_match;
                    crc_next     = CRC_INIT;
                    count_next   = POS_T_MSB;
                end
                default:
                begin
                    count_next = POS_T_MSB;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= POS_T_MSB;
            crc_reg       <= CRC_INIT;
            raw_temp_reg  <= '0;
            raw_hum_reg   <= '0;
            temp_good_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            raw_temp_reg  <= raw_temp_next;
            raw_hum_reg   <= raw_hum_next;
            temp_good_reg <= temp_good_next;
        end
    end

endmodule

/* src/sensor_frame_check_alarm_fan_top.sv */
// Sensor frame checker: CRC check, conversion, window alarms and fan hysteresis.
//
//   channel | dir | handshake    | payload
//   --------+-----+--------------+----------------------------------------------
//   rx      | in  | valid/ready  | rx_byte, frame_start
//   result  | out | valid/ready  | status, temp_centi, hum_centi, alarms, fan_on
//   cfg     | in  | cfg_we       | cfg_index, cfg_data
//
// One byte is taken per cycle while rx.ready is high; the sixth byte of a frame
// yields one result through the product, quotient and compare stages.
// Reset clears the byte count, CRC, alarms, fan and limits to their defaults.
// A stalled result holds the output register; bytes keep flowing until the
// product, quotient and output stages all hold a frame, then rx.ready drops.
module sensor_frame_check_alarm_fan_top
    import sfc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    sfc_in_if.sink                 rx,
    sfc_out_if.source              result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Limit registers
    logic signed [14:0] temp_high_reg, temp_low_reg;
    logic [13:0]        hum_high_reg, hum_low_reg;
    logic [10:0]        fan_band_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_high_reg <= TEMP_HIGH_RST;
            temp_low_reg  <= TEMP_LOW_RST;
            hum_high_reg  <= HUM_HIGH_RST;
            hum_low_reg   <= HUM_LOW_RST;
            fan_band_reg  <= FAN_BAND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TEMP_HIGH: temp_high_reg <= cfg_data;
                REG_TEMP_LOW:  temp_low_reg  <= cfg_data;
                REG_HUM_HIGH:  hum_high_reg  <= cfg_data[13:0];
                REG_HUM_LOW:   hum_low_reg   <= cfg_data[13:0];
                REG_FAN_BAND:  fan_band_reg  <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    logic out_free, p2_free, p1_free, p1_move, p2_move;
    logic p1_valid_reg, p2_valid_reg, out_valid_reg;
    logic rx_take;
    sfc_frame_t frame;

    assign out_free = !out_valid_reg || result.ready;
    assign p2_move  = p2_valid_reg && out_free;
    assign p2_free  = !p2_valid_reg || out_free;
    assign p1_move  = p1_valid_reg && p2_free;
    assign p1_free  = !p1_valid_reg || p2_free;
    assign rx.ready = p1_free;
    assign rx_take  = rx.valid && rx.ready;

    sfc_frame_rx u_frame_rx (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (rx_take),
        .rx_byte     (rx.rx_byte),
        .frame_start (rx.frame_start),
        .frame       (frame)
    );

    // Stage 1: scale products
    logic        p1_crc_ok_reg;
    logic [30:0] p1_tprod_reg;
    logic [29:0] p1_hprod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (frame.done)
            p1_valid_reg <= 1'b1;
        else if (p1_move)
            p1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (frame.done)
        begin
            p1_crc_ok_reg <= frame.crc_ok;
            p1_tprod_reg  <= {15'd0, frame.raw_temp} * {16'd0, TEMP_SCALE};
            p1_hprod_reg  <= {14'd0, frame.raw_hum} * {16'd0, HUM_SCALE};
        end
    end

    // Stage 2: divide by 65535 and offset temperature
    logic               p2_crc_ok_reg;
    logic signed [14:0] p2_temp_reg;
    logic [13:0]        p2_hum_reg;
    logic [14:0]        q_temp, q_hum;
    logic [15:0]        temp_wide;

    assign q_temp    = div_65535(p1_tprod_reg);
    assign q_hum     = div_65535({1'b0, p1_hprod_reg});
    assign temp_wide = {1'b0, q_temp} - TEMP_OFFSET;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (p1_move)
            p2_valid_reg <= 1'b1;
        else if (p2_move)
            p2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (p1_move)
        begin
            p2_crc_ok_reg <= p1_crc_ok_reg;
            p2_temp_reg   <= temp_wide[14:0];
            p2_hum_reg    <= q_hum[13:0];
        end
    end

    // Stage 3: status, alarms and fan hysteresis
    status_t            status_next;
    logic signed [14:0] temp_out;
    logic [13:0]        hum_out;
    logic signed [15:0] fan_off_thr;
    logic               in_range;
    logic               hum_alarm_reg, temp_alarm_reg, fan_reg;
    logic               hum_alarm_next, temp_alarm_next, fan_next;
    status_t            status_reg;
    logic signed [14:0] temp_out_reg;
    logic [13:0]        hum_out_reg;

    assign fan_off_thr = {temp_high_reg[14], temp_high_reg} - $signed({5'd0, fan_band_reg});
    assign in_range    = (p2_hum_reg <= HUM_MAX_OK) && (p2_temp_reg >= TEMP_MIN_OK)
                         && (p2_temp_reg <= TEMP_MAX_OK);

    always_comb
    begin
        status_next     = STATUS_OK;
        temp_out        = p2_temp_reg;
        hum_out         = p2_hum_reg;
        hum_alarm_next  = hum_alarm_reg;
        temp_alarm_next = temp_alarm_reg;
        fan_next        = fan_reg;
        priority if (!p2_crc_ok_reg)
        begin
            status_next = STATUS_CRC_ERR;
            temp_out    = '0;
            hum_out     = '0;
        end
        else if (!in_range)
        begin
            status_next = STATUS_RANGE;
        end
        else
        begin
            hum_alarm_next  = (p2_hum_reg < hum_low_reg) || (p2_hum_reg > hum_high_reg);
            temp_alarm_next = (p2_temp_reg < temp_low_reg) || (p2_temp_reg > temp_high_reg);
            if (p2_temp_reg > temp_high_reg)
                fan_next = 1'b1;
            else if ($signed({p2_temp_reg[14], p2_temp_reg}) < fan_off_thr)
                fan_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hum_alarm_reg  <= 1'b0;
            temp_alarm_reg <= 1'b0;
            fan_reg        <= 1'b0;
        end
        else if (p2_move)
        begin
            out_valid_reg  <= 1'b1;
            hum_alarm_reg  <= hum_alarm_next;
            temp_alarm_reg <= temp_alarm_next;
            fan_reg        <= fan_next;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_move)
        begin
            status_reg   <= status_next;
            temp_out_reg <= temp_out;
            hum_out_reg  <= hum_out;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.status     = status_reg;
    assign result.temp_centi = temp_out_reg;
    assign result.hum_centi  = hum_out_reg;
    assign result.hum_alarm  = hum_alarm_reg;
    assign result.temp_alarm = temp_alarm_reg;
    assign result.fan_on     = fan_reg;

    // A finished frame never lands on an occupied product stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (p1_valid_reg && !p2_free) |-> !frame.done)
        else $error("product stage overrun");

    // A CRC failure reports zeroed values
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == STATUS_CRC_ERR)
            |-> (result.temp_centi == 15'sd0 && result.hum_centi == 14'd0))
        else $error("crc error result carries values");

    // After a good frame the fan is never on below the turn-off threshold
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == STATUS_OK)
            |-> !(result.fan_on
                  && ($signed({result.temp_centi[14], result.temp_centi}) < fan_off_thr)))
        else $error("fan hysteresis violated");

endmodule

/* bench/sfc_frame_checker.sv */
// Scoreboard for the sensor frame checker: predicts every frame result and compares it.
module sfc_frame_checker
    import sfc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    sfc_in_if                      rx,
    sfc_out_if                     result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_cnt,
    output int                     pending,
    output int                     n_ok,
    output int                     n_crc,
    output int                     n_range
);
    timeunit 1ns;
    timeprecision 1ps;

    // Conversion: centi = floor(full * raw / 65535) - bias
    localparam int TEMP_FULL = 17500;
    localparam int TEMP_BIAS = 4500;
    localparam int HUM_FULL  = 10000;
    localparam int RAW_FULL  = 65535;

    typedef struct {
        status_t            status;
        logic signed [14:0] temp_centi;
        logic [13:0]        hum_centi;
        logic               hum_alarm;
        logic               temp_alarm;
        logic               fan_on;
    } frame_result_t;

    frame_result_t frame_results_q[$];

    // Limit registers as the block should hold them
    logic signed [14:0] temp_high_lim;
    logic signed [14:0] temp_low_lim;
    logic [13:0]        hum_high_lim;
    logic [13:0]        hum_low_lim;
    logic [10:0]        fan_band_lim;

    // Frame assembly and held flags
    byte_pos_t   byte_pos;
    logic [7:0]  crc_run;
    logic [15:0] raw_temp;
    logic [15:0] raw_hum;
    logic        temp_word_ok;
    logic        hum_alarm_q;
    logic        temp_alarm_q;
    logic        fan_q;

    int fails;
    int cnt_ok;
    int cnt_crc;
    int cnt_range;

    // CRC-8 poly 0x31, fed one bit at a time, MSB first
    function automatic logic [7:0] crc_update(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc;
        for (int k = 7; k >= 0; k--)
        begin
            if (r[7] ^ data[k])
                r = {r[6:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[6:0], 1'b0};
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t exp_res;
        byte_pos_t     cur;
        int            t_val;
        int            h_val;
        logic          hum_word_ok;
        if (!rst_n)
        begin
            temp_high_lim = TEMP_HIGH_RST;
            temp_low_lim  = TEMP_LOW_RST;
            hum_high_lim  = HUM_HIGH_RST;
            hum_low_lim   = HUM_LOW_RST;
            fan_band_lim  = FAN_BAND_RST;
            byte_pos      = POS_T_MSB;
            crc_run       = CRC_INIT;
            raw_temp      = '0;
            raw_hum       = '0;
            temp_word_ok  = 1'b0;
            hum_alarm_q   = 1'b0;
            temp_alarm_q  = 1'b0;
            fan_q         = 1'b0;
            frame_results_q.delete();
            fails     = 0;
            cnt_ok    = 0;
            cnt_crc   = 0;
            cnt_range = 0;
        end
        else
        begin
            // Register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TEMP_HIGH: temp_high_lim = cfg_data[14:0];
                    REG_TEMP_LOW:  temp_low_lim  = cfg_data[14:0];
                    REG_HUM_HIGH:  hum_high_lim  = cfg_data[13:0];
                    REG_HUM_LOW:   hum_low_lim   = cfg_data[13:0];
                    REG_FAN_BAND:  fan_band_lim  = cfg_data[10:0];
                    default: ;
                endcase
            end

            // Result transfer: compare against the oldest prediction
            if (result.valid && result.ready)
            begin
                if (frame_results_q.size() == 0)
                begin
                    $error("result transfer with nothing predicted: status %0d temp %0d hum %0d",
                           result.status, result.temp_centi, result.hum_centi);
                    fails++;
                end
                else
                begin
                    exp_res = frame_results_q.pop_front();
                    if (result.status !== exp_res.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp_res.status, result.status);
                        fails++;
                    end
                    if (result.temp_centi !== exp_res.temp_centi)
                    begin
                        $error("temp_centi: expected %0d, actual %0d",
                               exp_res.temp_centi, result.temp_centi);
                        fails++;
                    end
                    if (result.hum_centi !== exp_res.hum_centi)
                    begin
                        $error("hum_centi: expected %0d, actual %0d",
                               exp_res.hum_centi, result.hum_centi);
                        fails++;
                    end
                    if (result.hum_alarm !== exp_res.hum_alarm)
                    begin
                        $error("hum_alarm: expected %0b, actual %0b",
                               exp_res.hum_alarm, result.hum_alarm);
                        fails++;
                    end
                    if (result.temp_alarm !== exp_res.temp_alarm)
                    begin
                        $error("temp_alarm: expected %0b, actual %0b",
                               exp_res.temp_alarm, result.temp_alarm);
                        fails++;
                    end
                    if (result.fan_on !== exp_res.fan_on)
                    begin
                        $error("fan_on: expected %0b, actual %0b", exp_res.fan_on, result.fan_on);
                        fails++;
                    end
                    case (exp_res.status)
                        STATUS_OK:      cnt_ok++;
                        STATUS_CRC_ERR: cnt_crc++;
                        default:        cnt_range++;
                    endcase
                end
            end

            // Byte transfer: advance the frame and predict on the last byte
            if (rx.valid && rx.ready)
            begin
                if (rx.frame_start)
                begin
                    byte_pos = POS_T_MSB;
                    crc_run  = CRC_INIT;
                end
                cur      = byte_pos;
                byte_pos = (cur == POS_H_CRC) ? POS_T_MSB : byte_pos_t'(cur + 3'd1);
                case (cur)
                    POS_T_MSB:
                    begin
                        raw_temp[15:8] = rx.rx_byte;
                        crc_run = crc_update(crc_run, rx.rx_byte);
                    end
                    POS_T_LSB:
                    begin
                        raw_temp[7:0] = rx.rx_byte;
                        crc_run = crc_update(crc_run, rx.rx_byte);
                    end
                    POS_T_CRC:
                    begin
                        temp_word_ok = (rx.rx_byte == crc_run);
                        crc_run = CRC_INIT;
                    end
                    POS_H_MSB:
                    begin
                        raw_hum[15:8] = rx.rx_byte;
                        crc_run = crc_update(crc_run, rx.rx_byte);
                    end
                    POS_H_LSB:
                    begin
                        raw_hum[7:0] = rx.rx_byte;
                        crc_run = crc_update(crc_run, rx.rx_byte);
                    end
                    default:
                    begin
                        hum_word_ok = (rx.rx_byte == crc_run);
                        crc_run = CRC_INIT;
                        t_val = (TEMP_FULL * int'(raw_temp)) / RAW_FULL - TEMP_BIAS;
                        h_val = (HUM_FULL * int'(raw_hum)) / RAW_FULL;
                        if (!temp_word_ok || !hum_word_ok)
                        begin
                            // CRC wins over range; values are zeroed, flags held
                            exp_res.status = STATUS_CRC_ERR;
                            t_val = 0;
                            h_val = 0;
                        end
                        else if (h_val > int'(HUM_MAX_OK) || t_val < int'(TEMP_MIN_OK) ||
                                 t_val > int'(TEMP_MAX_OK))
                        begin
                            exp_res.status = STATUS_RANGE;
                        end
                        else
                        begin
                            exp_res.status = STATUS_OK;
                            hum_alarm_q  = (h_val < int'(hum_low_lim)) ||
                                           (h_val > int'(hum_high_lim));
                            temp_alarm_q = (t_val < int'(temp_low_lim)) ||
                                           (t_val > int'(temp_high_lim));
                            // Hysteresis: on above the high limit, off below it minus the band
                            if (t_val > int'(temp_high_lim) && !fan_q)
                                fan_q = 1'b1;
                            if (t_val < int'(temp_high_lim) - int'(fan_band_lim) && fan_q)
                                fan_q = 1'b0;
                        end
                        exp_res.temp_centi = t_val[14:0];
                        exp_res.hum_centi  = h_val[13:0];
                        exp_res.hum_alarm  = hum_alarm_q;
                        exp_res.temp_alarm = temp_alarm_q;
                        exp_res.fan_on     = fan_q;
                        frame_results_q.push_back(exp_res);
                    end
                endcase
            end
        end

        fail_cnt <= fails;
        pending  <= frame_results_q.size();
        n_ok     <= cnt_ok;
        n_crc    <= cnt_crc;
        n_range  <= cnt_range;
    end

endmodule

/* bench/sensor_frame_check_alarm_fan_top_tb.sv */
// Testbench top for the sensor frame checker: clock, reset, frame stimulus and verdict.
module sensor_frame_check_alarm_fan_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfc_pkg::*;

    localparam int ITEMS_TARGET  = 1950;
    localparam int N_PHASES      = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 10;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int src_idle_pct;
    int sink_idle_pct;
    int bytes_sent;
    int cycle_cnt;
    int fail_cnt;
    int pending;
    int n_ok;
    int n_crc;
    int n_range;

    // Limits currently programmed, used to aim stimulus at the thresholds
    int cur_t_hi;
    int cur_t_lo;
    int cur_h_hi;
    int cur_h_lo;
    int cur_band;

    sfc_in_if  rx_ch();
    sfc_out_if res_ch();

    sensor_frame_check_alarm_fan_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sfc_frame_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fail_cnt  (fail_cnt),
        .pending   (pending),
        .n_ok      (n_ok),
        .n_crc     (n_crc),
        .n_range   (n_range)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge clk)
        res_ch.ready <= rst_n && ($urandom_range(99) >= sink_idle_pct);

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One byte transfer, with random idle cycles ahead of it
    task automatic put_byte(input logic [7:0] data, input logic start);
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid       <= 1'b1;
        rx_ch.rx_byte     <= data;
        rx_ch.frame_start <= start;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        bytes_sent++;
    endtask

    // Build a frame with correct CRCs, optionally corrupt one or both, send n_bytes of it
    task automatic send_frame(input logic [15:0] raw_t, input logic [15:0] raw_h,
                              input logic start, input logic [1:0] bad_crc, input int n_bytes);
        logic [7:0] frame_bytes [6];
        frame_bytes[0] = raw_t[15:8];
        frame_bytes[1] = raw_t[7:0];
        frame_bytes[2] = crc8_byte(crc8_byte(CRC_INIT, frame_bytes[0]), frame_bytes[1]);
        frame_bytes[3] = raw_h[15:8];
        frame_bytes[4] = raw_h[7:0];
        frame_bytes[5] = crc8_byte(crc8_byte(CRC_INIT, frame_bytes[3]), frame_bytes[4]);
        if (bad_crc[0])
            frame_bytes[2] ^= 8'($urandom_range(255, 1));
        if (bad_crc[1])
            frame_bytes[5] ^= 8'($urandom_range(255, 1));
        for (int i = 0; i < n_bytes; i++)
            put_byte(frame_bytes[i], start && i == 0);
    endtask

    // Stop sending and wait for every predicted result plus pipeline drain
    task automatic drain();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all five limit registers, back to back
    task automatic set_limits(input int t_hi, input int t_lo, input int h_hi, input int h_lo,
                              input int band);
        logic [CFG_DATA_W-1:0] vals [5];
        cfg_reg_t              idx;
        vals[REG_TEMP_HIGH] = t_hi[14:0];
        vals[REG_TEMP_LOW]  = t_lo[14:0];
        vals[REG_HUM_HIGH]  = h_hi[14:0];
        vals[REG_HUM_LOW]   = h_lo[14:0];
        vals[REG_FAN_BAND]  = band[14:0];
        idx = idx.first();
        repeat (idx.num())
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[idx];
            @(posedge clk);
            idx = idx.next();
        end
        cfg_we <= 1'b0;
        cur_t_hi = int'($signed(t_hi[14:0]));
        cur_t_lo = int'($signed(t_lo[14:0]));
        cur_h_hi = h_hi & 32'h3FFF;
        cur_h_lo = h_lo & 32'h3FFF;
        cur_band = band & 32'h7FF;
    endtask

    // Raw temperature word, mostly near the alarm/fan thresholds and range edges
    function automatic logic [15:0] raw_pick_temp();
        int t;
        case ($urandom_range(9))
            0, 1:    t = cur_t_hi + int'($urandom_range(600)) - 300;
            2, 3:    t = cur_t_hi - cur_band + int'($urandom_range(600)) - 300;
            4, 5:    t = cur_t_lo + int'($urandom_range(600)) - 300;
            6, 7:    t = int'($urandom_range(16500)) - 4000;
            8:       t = $urandom_range(1) ? -4000 - int'($urandom_range(1))
                                           : 12500 + int'($urandom_range(1));
            default: return 16'($urandom_range(65535));
        endcase
        if (t < -4500)
            t = -4500;
        if (t > 13000)
            t = 13000;
        // smallest raw whose floored conversion lands on t
        return 16'(((t + 4500) * 65535 + 17499) / 17500);
    endfunction

    // Raw humidity word, mostly near the window edges
    function automatic logic [15:0] raw_pick_hum();
        int h;
        case ($urandom_range(5))
            0, 1:    h = cur_h_hi + int'($urandom_range(400)) - 200;
            2, 3:    h = cur_h_lo + int'($urandom_range(400)) - 200;
            4:       h = int'($urandom_range(10000));
            default: return 16'($urandom_range(65535));
        endcase
        if (h < 0)
            h = 0;
        if (h > 10000)
            h = 10000;
        return 16'((h * 65535 + 9999) / 10000);
    endfunction

    initial
    begin
        int stop_at;
        int kind;
        int lo;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        rx_ch.valid       = 1'b0;
        rx_ch.rx_byte     = '0;
        rx_ch.frame_start = 1'b0;
        res_ch.ready      = 1'b0;
        src_idle_pct      = 21;
        sink_idle_pct     = 54;
        cur_t_hi          = int'(TEMP_HIGH_RST);
        cur_t_lo          = int'(TEMP_LOW_RST);
        cur_h_hi          = int'(HUM_HIGH_RST);
        cur_h_lo          = int'(HUM_LOW_RST);
        cur_band          = int'(FAN_BAND_RST);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all-zero bytes with a bad humidity CRC
        send_frame(16'h0000, 16'h0000, 1'b1, 2'b10, 6);
        // all-ones bytes: good CRCs, temperature above the accepted range
        send_frame(16'hFFFF, 16'hFFFF, 1'b1, 2'b00, 6);
        // no start mark, 45.00 C / 70.00 %: both alarms, fan turns on
        send_frame(16'd33704, 16'd45875, 1'b0, 2'b00, 6);
        // lone start byte, then a restart: 39.00 C stays inside the band, fan held on
        put_byte(8'hA5, 1'b1);
        send_frame(16'd31457, 16'd29491, 1'b1, 2'b00, 6);

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    src_idle_pct  = 21;
                    sink_idle_pct = 54;
                end
                1:
                begin
                    src_idle_pct  = 54;
                    sink_idle_pct = 21;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase

            // Limit settings; the first phase keeps the reset values
            case (phase)
                0: ;
                1: set_limits(int'($urandom_range(17500)) - 4500,
                              int'($urandom_range(17500)) - 4500,
                              $urandom_range(10000), $urandom_range(10000),
                              $urandom_range(2000));
                2: set_limits(-4500, 13000, 0, 10000, 0);
                3: set_limits(13000, -4500, 10000, 0, 2000);
                4: set_limits($urandom_range(32767), $urandom_range(32767),
                              $urandom_range(32767), $urandom_range(32767),
                              $urandom_range(32767));
                default:
                begin
                    lo = $urandom_range(3000);
                    set_limits(lo + 500 + int'($urandom_range(2500)), lo,
                               7000, 3000, 100 + int'($urandom_range(700)));
                end
            endcase

            stop_at = ITEMS_TARGET * (phase + 1) / N_PHASES;
            while (bytes_sent < stop_at)
            begin
                kind = $urandom_range(99);
                if (kind < 72)
                    send_frame(raw_pick_temp(), raw_pick_hum(), 1'b1, 2'b00, 6);
                else if (kind < 80)
                    send_frame(raw_pick_temp(), raw_pick_hum(), 1'b0, 2'b00, 6);
                else if (kind < 88)
                    send_frame(raw_pick_temp(), raw_pick_hum(), 1'b1,
                               2'($urandom_range(3, 1)), 6);
                else if (kind < 94)
                    send_frame(raw_pick_temp(), raw_pick_hum(), 1'b1, 2'b00,
                               $urandom_range(5, 1));
                else
                    repeat ($urandom_range(8, 1))
                        put_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
                // occasionally hold off until the pipeline is empty
                if ($urandom_range(49) == 0)
                    drain();
            end
            drain();
        end

        $display("Drove %0d frame bytes across %0d limit settings and three idle profiles",
                 bytes_sent, N_PHASES);
        $display("Checked %0d results: %0d accepted, %0d CRC errors, %0d out of range",
                 n_ok + n_crc + n_range, n_ok, n_crc, n_range);
        if (fail_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
src/sfc_pkg.sv
src/sfc_if.sv
src/sfc_frame_rx.sv
src/sensor_frame_check_alarm_fan_top.sv
bench/sfc_frame_checker.sv
bench/sensor_frame_check_alarm_fan_top_tb.sv
